// ===== design/ballistic_jump_trajectory_top_defines.svh =====
// Assertion helpers for the ballistic jump trajectory block.
// Both forms sample on clk and are off while rst_n is low.
`ifndef BALLISTIC_JUMP_TRAJECTORY_TOP_DEFINES_SVH
`define BALLISTIC_JUMP_TRAJECTORY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BJT_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("bjt invariant violated");
`define BJT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bjt sequence violated");
`else
`define BJT_ASSERT(lbl, expr)
`define BJT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ===== design/bjt_pkg.sv =====
`timescale 1ns / 1ps
package bjt_pkg;

  localparam int POS_W   = 32;   // Q16.16 position
  localparam int TIME_W  = 32;   // ms time stamp
  localparam int FC_W    = 16;   // frame count
  localparam int FC_MAX  = 65535;
  localparam int Q_W     = 33;   // |end - start| and quotient magnitude
  localparam int LIN_W   = Q_W + 1;
  localparam int CNT_W   = 6;    // counts Q_W divide steps
  localparam int G40_W   = 24;
  localparam int G_SHIFT = 25;
  localparam int HUMP_W  = 40;
  localparam int Y_W     = HUMP_W + 2;
  localparam int CFG_AW  = 3;

  // gravity per ms^2 scaled by 2^40
  localparam logic [G40_W-1:0]  G40       = 24'd10782526;
  localparam logic [TIME_W-1:0] LIN_T_MAX = 32'd131072;
  localparam logic [HUMP_W-1:0] HUMP_MAX  = {HUMP_W{1'b1}};

  typedef logic [CFG_AW-1:0] reg_idx_t;

  localparam reg_idx_t REG_START_X     = 3'd0;
  localparam reg_idx_t REG_START_Y     = 3'd1;
  localparam reg_idx_t REG_START_Z     = 3'd2;
  localparam reg_idx_t REG_END_X       = 3'd3;
  localparam reg_idx_t REG_END_Y       = 3'd4;
  localparam reg_idx_t REG_END_Z       = 3'd5;
  localparam reg_idx_t REG_FRAME_COUNT = 3'd6;
  localparam reg_idx_t REG_START_TIME  = 3'd7;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    OP_DROP_A = 3'd0,   // tot * tot
    OP_DROP_B = 3'd1,   // * G40
    OP_HUMP_A = 3'd2,   // dt * (tot - dt)
    OP_HUMP_B = 3'd3,   // * G40
    OP_X      = 3'd4,   // |dx| * dt / tot
    OP_Y      = 3'd5,
    OP_Z      = 3'd6
  } op_t;

endpackage

// ===== design/ballistic_jump_trajectory_top.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// --------+-----+--------------------+----------------------------------------------
// in      | in  | in_tvalid/tready   | in_tdata: now_time
// out     | out | out_tvalid/tready  | out_tdata: pos_x,pos_y,pos_z; tuser pos_valid;
//         |     |                    | tlast finished
// cfg     | in  | cfg_valid/cfg_ready| cfg_addr register index, cfg_wdata value
//
// One word at a time. A word taken after the jump ended is dropped in its accept
// cycle. A word with no position to work out (before start, at or past the end)
// goes straight to the output state. Otherwise the shared shift-add multiplier
// runs seven products (one multiplier bit per cycle, ends when the multiplier
// empties) and the restoring divider runs three 33-step quotients.
// Reset (rst_n low, synchronous) restores the register defaults and clears the
// done flag; no clearing pass. A result waiting at the output does not stop the
// next word from being taken; the sequencer only waits if the output is still full.
`include "ballistic_jump_trajectory_top_defines.svh"

module ballistic_jump_trajectory_top #(
  parameter int FRAME_TIME = 33
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] now_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
  output logic        out_tuser,   // [0] pos_valid
  output logic        out_tlast,   // finished
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);
  import bjt_pkg::*;

  // total time = FRAME_TIME * frame_count, held ready for use
  localparam int TOT_W = $clog2(FRAME_TIME * FC_MAX + 1);
  localparam int ACC_W = 2 * TOT_W + G40_W;
  localparam int MPL_W = (TOT_W > G40_W) ? TOT_W : G40_W;
  localparam int DIV_W = TOT_W + Q_W;

  // configuration
  logic [POS_W-1:0]  start_x_r, start_y_r, start_z_r, end_x_r, end_y_r, end_z_r;
  logic [POS_W-1:0]  start_x_nxt, start_y_nxt, start_z_nxt;
  logic [POS_W-1:0]  end_x_nxt, end_y_nxt, end_z_nxt;
  logic [TIME_W-1:0] start_time_r, start_time_nxt;
  logic [TOT_W-1:0]  tot_r, tot_nxt;

  // control
  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   done_r, done_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  // datapath
  logic [TOT_W-1:0]  dt_r, dt_nxt;
  logic              pv_r, pv_nxt, fin_r, fin_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt, mcand_r, mcand_nxt;
  logic [MPL_W-1:0]  mplier_r, mplier_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              neg_r, neg_nxt, linear_r, linear_nxt;
  logic [HUMP_W-1:0] hump_r, hump_nxt;
  logic [LIN_W-1:0]  lin_x_r, lin_y_r, lin_z_r, lin_x_nxt, lin_y_nxt, lin_z_nxt;
  logic [95:0]       out_tdata_r, out_tdata_nxt;
  logic              out_tuser_r, out_tuser_nxt, out_tlast_r, out_tlast_nxt;

  // combinational helpers
  logic [FC_W-1:0]   fc_clamp;
  logic [TIME_W-1:0] now_dt;
  logic              now_pv, now_fin;
  logic [POS_W-1:0]  sel_s, sel_e;
  logic [Q_W-1:0]    d_diff, d_abs, ndy;
  logic              d_neg;
  logic [ACC_W-1:0]  g_shr;
  logic              lin_sel;
  logic [HUMP_W-1:0] hump_sat;
  logic [TOT_W:0]    trial, trial_sub;
  logic              div_ge;
  logic [DIV_W-1:0]  div_step;
  logic [LIN_W-1:0]  lin_val;
  logic [LIN_W-1:0]  x_sum, z_sum;
  logic [Y_W-1:0]    y_sum;
  logic [POS_W-1:0]  y_sat;

  assign fc_clamp = (cfg_wdata[FC_W-1:0] == '0) ? FC_W'(1) : cfg_wdata[FC_W-1:0];

  assign now_dt  = in_tdata - start_time_r;
  assign now_pv  = in_tdata >= start_time_r;
  assign now_fin = now_dt >= TIME_W'(tot_r);

  // axis operands for the linear term
  assign sel_s = (op_r == OP_Y) ? start_y_r : (op_r == OP_Z) ? start_z_r : start_x_r;
  assign sel_e = (op_r == OP_Y) ? end_y_r   : (op_r == OP_Z) ? end_z_r   : end_x_r;
  assign d_diff = {sel_e[POS_W-1], sel_e} - {sel_s[POS_W-1], sel_s};
  assign d_neg  = d_diff[Q_W-1];
  assign d_abs  = d_neg ? -d_diff : d_diff;

  // steep-drop: linear when tot <= LIN_T_MAX and free-fall drop < start_y - end_y
  assign ndy     = {start_y_r[POS_W-1], start_y_r} - {end_y_r[POS_W-1], end_y_r};
  assign g_shr   = acc_r >> G_SHIFT;
  assign lin_sel = (TIME_W'(tot_r) <= LIN_T_MAX) && !ndy[Q_W-1] && (ndy != '0) &&
                   (g_shr < ACC_W'(ndy));
  assign hump_sat = (g_shr > ACC_W'(HUMP_MAX)) ? HUMP_MAX : g_shr[HUMP_W-1:0];

  // one restoring divide step; remainder always stays below tot
  assign trial     = {div_r[DIV_W-1:Q_W], div_r[Q_W-1]};
  assign trial_sub = trial - {1'b0, tot_r};
  assign div_ge    = trial >= {1'b0, tot_r};
  assign div_step  = {(div_ge ? trial_sub[TOT_W-1:0] : trial[TOT_W-1:0]),
                      div_r[Q_W-2:0], div_ge};
  assign lin_val   = neg_r ? -{1'b0, div_step[Q_W-1:0]} : {1'b0, div_step[Q_W-1:0]};

  // final position assembly
  assign x_sum = {{(LIN_W-POS_W){start_x_r[POS_W-1]}}, start_x_r} + lin_x_r;
  assign z_sum = {{(LIN_W-POS_W){start_z_r[POS_W-1]}}, start_z_r} + lin_z_r;
  assign y_sum = {{(Y_W-POS_W){start_y_r[POS_W-1]}}, start_y_r} +
                 {{(Y_W-LIN_W){lin_y_r[LIN_W-1]}}, lin_y_r} +
                 (linear_r ? Y_W'(0) : Y_W'(hump_r));
  always_comb begin
    if (y_sum[Y_W-1:POS_W-1] == '0 || y_sum[Y_W-1:POS_W-1] == '1) begin
      y_sat = y_sum[POS_W-1:0];
    end else if (y_sum[Y_W-1]) begin
      y_sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      y_sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  always_comb begin
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    start_z_nxt    = start_z_r;
    end_x_nxt      = end_x_r;
    end_y_nxt      = end_y_r;
    end_z_nxt      = end_z_r;
    start_time_nxt = start_time_r;
    tot_nxt        = tot_r;
    state_nxt      = state_r;
    op_nxt         = op_r;
    done_nxt       = done_r;
    out_tvalid_nxt = out_tvalid_r;
    dt_nxt         = dt_r;
    pv_nxt         = pv_r;
    fin_nxt        = fin_r;
    acc_nxt        = acc_r;
    mcand_nxt      = mcand_r;
    mplier_nxt     = mplier_r;
    div_nxt        = div_r;
    cnt_nxt        = cnt_r;
    neg_nxt        = neg_r;
    linear_nxt     = linear_r;
    hump_nxt       = hump_r;
    lin_x_nxt      = lin_x_r;
    lin_y_nxt      = lin_y_r;
    lin_z_nxt      = lin_z_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;

    if (cfg_valid) begin
      unique case (cfg_addr)
        REG_START_X:     start_x_nxt    = cfg_wdata;
        REG_START_Y:     start_y_nxt    = cfg_wdata;
        REG_START_Z:     start_z_nxt    = cfg_wdata;
        REG_END_X:       end_x_nxt      = cfg_wdata;
        REG_END_Y:       end_y_nxt      = cfg_wdata;
        REG_END_Z:       end_z_nxt      = cfg_wdata;
        REG_FRAME_COUNT: tot_nxt        = TOT_W'(FRAME_TIME * int'(fc_clamp));
        REG_START_TIME:  start_time_nxt = cfg_wdata;
      endcase
    end

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        // words arriving after the jump ended are swallowed
        if (in_tvalid && !done_r) begin
          done_nxt = now_fin;
          dt_nxt   = now_dt[TOT_W-1:0];
          pv_nxt   = now_pv;
          fin_nxt  = now_fin;
          if (now_pv && !now_fin) begin
            op_nxt    = OP_DROP_A;
            state_nxt = ST_LOAD;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_LOAD: begin
        acc_nxt   = '0;
        state_nxt = ST_MUL;
        unique case (op_r)
          OP_DROP_A: begin
            mcand_nxt  = ACC_W'(tot_r);
            mplier_nxt = MPL_W'(tot_r);
          end
          OP_DROP_B, OP_HUMP_B: begin
            mcand_nxt  = acc_r;
            mplier_nxt = MPL_W'(G40);
          end
          OP_HUMP_A: begin
            mcand_nxt  = ACC_W'(dt_r);
            mplier_nxt = MPL_W'(tot_r - dt_r);
          end
          OP_X, OP_Y, OP_Z: begin
            mcand_nxt  = ACC_W'(d_abs);
            mplier_nxt = MPL_W'(dt_r);
            neg_nxt    = d_neg;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_MUL: begin
        if (mplier_r == '0) begin
          unique case (op_r)
            OP_DROP_A: begin
              op_nxt    = OP_DROP_B;
              state_nxt = ST_LOAD;
            end
            OP_DROP_B: begin
              linear_nxt = lin_sel;
              op_nxt     = OP_HUMP_A;
              state_nxt  = ST_LOAD;
            end
            OP_HUMP_A: begin
              op_nxt    = OP_HUMP_B;
              state_nxt = ST_LOAD;
            end
            OP_HUMP_B: begin
              hump_nxt  = hump_sat;
              op_nxt    = OP_X;
              state_nxt = ST_LOAD;
            end
            OP_X, OP_Y, OP_Z: begin
              div_nxt   = acc_r[DIV_W-1:0];
              cnt_nxt   = '0;
              state_nxt = ST_DIV;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end else begin
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt  = mcand_r << 1;
          mplier_nxt = mplier_r >> 1;
        end
      end
      ST_DIV: begin
        div_nxt = div_step;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          unique case (op_r)
            OP_X: begin
              lin_x_nxt = lin_val;
              op_nxt    = OP_Y;
              state_nxt = ST_LOAD;
            end
            OP_Y: begin
              lin_y_nxt = lin_val;
              op_nxt    = OP_Z;
              state_nxt = ST_LOAD;
            end
            OP_Z: begin
              lin_z_nxt = lin_val;
              state_nxt = ST_OUT;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = pv_r;
          out_tlast_nxt  = fin_r;
          if (pv_r && fin_r) begin
            out_tdata_nxt = {end_z_r, end_y_r, end_x_r};
          end else if (pv_r) begin
            out_tdata_nxt = {z_sum[POS_W-1:0], y_sat, x_sum[POS_W-1:0]};
          end else begin
            out_tdata_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r    <= '0;
      start_y_r    <= '0;
      start_z_r    <= '0;
      end_x_r      <= '0;
      end_y_r      <= '0;
      end_z_r      <= '0;
      start_time_r <= '0;
      tot_r        <= TOT_W'(FRAME_TIME);
      state_r      <= ST_IDLE;
      op_r         <= OP_DROP_A;
      done_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      start_x_r    <= start_x_nxt;
      start_y_r    <= start_y_nxt;
      start_z_r    <= start_z_nxt;
      end_x_r      <= end_x_nxt;
      end_y_r      <= end_y_nxt;
      end_z_r      <= end_z_nxt;
      start_time_r <= start_time_nxt;
      tot_r        <= tot_nxt;
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      done_r       <= done_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r        <= dt_nxt;
    pv_r        <= pv_nxt;
    fin_r       <= fin_nxt;
    acc_r       <= acc_nxt;
    mcand_r     <= mcand_nxt;
    mplier_r    <= mplier_nxt;
    div_r       <= div_nxt;
    cnt_r       <= cnt_nxt;
    neg_r       <= neg_nxt;
    linear_r    <= linear_nxt;
    hump_r      <= hump_nxt;
    lin_x_r     <= lin_x_nxt;
    lin_y_r     <= lin_y_nxt;
    lin_z_r     <= lin_z_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  // divider remainder never reaches the divisor
  `BJT_ASSERT(a_div_rem_bound, (state_r != ST_DIV) || (div_r[DIV_W-1:Q_W] < tot_r))
  // the multiply sequence only runs for times inside the jump
  `BJT_ASSERT(a_dt_in_jump, (state_r != ST_MUL) || (dt_r < tot_r))
  // a word taken after the jump ended starts no work
  `BJT_ASSERT_NEXT(a_done_swallow, in_tvalid && in_tready && done_r, state_r == ST_IDLE)
  // a finishing result always goes with the latched done flag
  `BJT_ASSERT(a_last_done, !(out_tvalid && out_tlast) || done_r)

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Drives time stamps into the jump trajectory block, predicts each position
// word in SV arithmetic and checks the result stream word by word.
// The done flag only clears on reset and reset happens once, so every word
// before the last test keeps the jump active and the landing comes last.
module tb_top;
  import bjt_pkg::*;

  localparam int FRAME_TIME_MS = 33;
  localparam int QUIET_LIMIT   = 4000;  // worst-case time of one word, plus stalls
  localparam int DRAIN_CYCLES  = 400;   // covers one full word of block latency
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               pos_valid;
    logic               finished;
  } traj_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  reg_idx_t    cfg_addr;
  logic [31:0] cfg_wdata;

  ballistic_jump_trajectory_top #(
    .FRAME_TIME(FRAME_TIME_MS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the flight registers and the done flag
  logic signed [31:0] org_x, org_y, org_z;
  logic signed [31:0] dst_x, dst_y, dst_z;
  logic [15:0]        frames;
  logic [31:0]        launch_time;
  bit                 jump_done;

  traj_word_t expected_positions[$];
  traj_word_t got_word;
  traj_word_t want_word;
  int         failures;
  int         quiet_cycles;
  int         idle_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Sink side: random stalls at the same rate as the source gaps
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // floor(G * p / 2^25), G = gravity per ms^2 scaled by 2^40
  function automatic longint unsigned gravity_q16(input longint unsigned p);
    logic [127:0] prod;
    prod = {64'd0, p} * {104'd0, G40};
    return prod[G_SHIFT +: 64];
  endfunction

  // d * t / tot, rounded toward zero
  function automatic longint lerp_offset(input longint d, input longint unsigned t,
                                         input longint unsigned tot);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q   = mag * t / tot;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int unsigned flight_ms();
    return FRAME_TIME_MS * frames;
  endfunction

  // Returns 0 when the block must stay silent (jump already landed)
  function automatic bit predict_position(input logic [31:0] now, output traj_word_t w);
    logic [31:0]     dt;
    longint unsigned tot;
    longint unsigned hump;
    longint          dx, dy, dz, px, py, pz;
    bit              fin;
    bit              linear;
    w = '0;
    if (jump_done) return 1'b0;
    dt  = now - launch_time;
    tot = flight_ms();
    fin = (dt >= tot);
    if (now >= launch_time) begin
      w.pos_valid = 1'b1;
      if (fin) begin
        w.pos_x = dst_x;
        w.pos_y = dst_y;
        w.pos_z = dst_z;
      end else begin
        dx = longint'(dst_x) - longint'(org_x);
        dy = longint'(dst_y) - longint'(org_y);
        dz = longint'(dst_z) - longint'(org_z);
        // past ~2^17 ms free fall outruns any height change
        linear = (tot <= LIN_T_MAX) && (longint'(gravity_q16(tot * tot)) < -dy);
        px = longint'(org_x) + lerp_offset(dx, dt, tot);
        pz = longint'(org_z) + lerp_offset(dz, dt, tot);
        py = longint'(org_y) + lerp_offset(dy, dt, tot);
        if (!linear) begin
          hump = gravity_q16(dt * (tot - dt));
          if (hump > HUMP_MAX) hump = HUMP_MAX;
          py = py + longint'(hump);
        end
        if (py > longint'(32'sh7FFF_FFFF)) py = longint'(32'sh7FFF_FFFF);
        if (py < longint'(32'sh8000_0000)) py = longint'(32'sh8000_0000);
        w.pos_x = px[31:0];
        w.pos_y = py[31:0];
        w.pos_z = pz[31:0];
      end
    end
    w.finished = fin;
    if (fin) jump_done = 1'b1;
    return 1'b1;
  endfunction

  function automatic void apply_register(input reg_idx_t idx, input logic [31:0] v);
    case (idx)
      REG_START_X:     org_x = v;
      REG_START_Y:     org_y = v;
      REG_START_Z:     org_z = v;
      REG_END_X:       dst_x = v;
      REG_END_Y:       dst_y = v;
      REG_END_Z:       dst_z = v;
      REG_FRAME_COUNT: frames = (v[15:0] == 16'd0) ? 16'd1 : v[15:0];
      REG_START_TIME:  launch_time = v;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic string word_text(input traj_word_t w);
    return $sformatf("x=%h y=%h z=%h valid=%0b fin=%0b",
                     w.pos_x, w.pos_y, w.pos_z, w.pos_valid, w.finished);
  endfunction

  function automatic void note_failure(input string what);
    failures++;
    if (failures <= REPORT_MAX) $display("mismatch: %s", what);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word.pos_x     = out_tdata[31:0];
      got_word.pos_y     = out_tdata[63:32];
      got_word.pos_z     = out_tdata[95:64];
      got_word.pos_valid = out_tuser;
      got_word.finished  = out_tlast;
      if (expected_positions.size() == 0) begin
        note_failure({"word with nothing pending: ", word_text(got_word)});
      end else begin
        want_word = expected_positions.pop_front();
        if (got_word.pos_x !== want_word.pos_x || got_word.pos_y !== want_word.pos_y ||
            got_word.pos_z !== want_word.pos_z ||
            got_word.pos_valid !== want_word.pos_valid ||
            got_word.finished !== want_word.finished)
          note_failure({"want ", word_text(want_word), " got ", word_text(got_word)});
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  task automatic send_time(input logic [31:0] now);
    traj_word_t w;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= now;
    do @(posedge clk); while (!in_tready);
    if (predict_position(now, w)) expected_positions.push_back(w);
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Every word before the landing yields a result, so an empty queue means idle
  task automatic wait_idle();
    while (expected_positions.size() != 0) @(posedge clk);
  endtask

  task automatic load_trajectory(input logic [31:0] sx, input logic [31:0] sy,
                                 input logic [31:0] sz, input logic [31:0] ex,
                                 input logic [31:0] ey, input logic [31:0] ez,
                                 input logic [31:0] frames_word,
                                 input logic [31:0] t0);
    wait_idle();
    write_register(REG_START_X, sx);
    write_register(REG_START_Y, sy);
    write_register(REG_START_Z, sz);
    write_register(REG_END_X, ex);
    write_register(REG_END_Y, ey);
    write_register(REG_END_Z, ez);
    write_register(REG_FRAME_COUNT, frames_word);
    write_register(REG_START_TIME, t0);
  endtask

  // ---------------------------------------------------------------------------
  // Random pickers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] pick_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(4))
      1: return {{12{r[19]}}, r[19:0]};
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return r;
    endcase
  endfunction

  // Upper half is junk the block must drop; zero low half gets clamped
  function automatic logic [31:0] pick_frames_word();
    logic [31:0] r;
    logic [15:0] lo;
    r = $urandom;
    case ($urandom_range(4))
      0: lo = 16'($urandom_range(1, 8));
      1: lo = 16'($urandom_range(3900, 4050));  // straddles the 2^17 ms cutoff
      2: lo = 16'($urandom_range(1, 65535));
      3: lo = 16'hFFFF;
      default: lo = 16'h0000;
    endcase
    return {r[31:16], lo};
  endfunction

  function automatic logic [31:0] pick_start_time();
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 2000000);  // flight wraps past zero
      default: return $urandom;
    endcase
  endfunction

  // Elapsed time strictly inside the flight so the jump never lands here
  function automatic logic [31:0] pick_dt(input int unsigned tot);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return tot - 1;
      2, 3: return $urandom_range(0, (tot > 8) ? 7 : tot - 1);
      default: return $urandom_range(0, tot - 1);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults: everything at zero, one frame
  task automatic test_reset_defaults();
    send_time(32'd0);
    send_time(32'd17);
    send_time(32'd32);
  endtask

  // Full-scale spans on x and z, zero span on y, longest flight; y hump saturates high
  task automatic test_axis_extremes();
    int unsigned tot;
    load_trajectory(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h0000_FFFF, 32'd0);
    tot = flight_ms();
    send_time(32'd0);
    send_time(32'd1);
    send_time(tot / 2);
    send_time(tot - 1);
    send_time(32'h0000_FFFF);
  endtask

  // Drop far steeper than free fall: straight line on y; z has zero span
  task automatic test_steep_drop();
    load_trajectory(32'hFFFF_FFFF, 32'h4000_0000, 32'h1234_5678,
                    32'h0000_0001, 32'hC000_0000, 32'h1234_5678,
                    32'hFFFF_0003, 32'h8000_0000);
    send_time(32'h8000_0000);
    send_time(32'h8000_0032);
    send_time(32'h8000_0062);
  endtask

  // Three frames drop 3149 in Q16.16; one step either side of the boundary
  task automatic test_fall_boundary();
    load_trajectory(32'd0, 32'd0, 32'd0, 32'd0, -32'sd3149, 32'd0,
                    32'd3, 32'd1000);
    send_time(32'd1001);
    send_time(32'd1049);
    wait_idle();
    write_register(REG_END_Y, -32'sd3150);
    send_time(32'd1001);
    send_time(32'd1049);
  endtask

  // Flight straddles the 32-bit wrap; words past zero carry no position
  task automatic test_wrapped_start();
    logic [31:0] p;
    p = $urandom;
    load_trajectory(p, p, p, p, p, p, 32'd100, 32'hFFFF_FFF0);
    send_time(32'hFFFF_FFF5);
    send_time(32'hFFFF_FFFF);
    send_time(32'h0000_0000);
    send_time(32'd3000);
  endtask

  // Zero frame count must behave as one frame
  task automatic test_zero_frame_count();
    wait_idle();
    write_register(REG_FRAME_COUNT, 32'h5A5A_0000);
    write_register(REG_START_TIME, 32'd100);
    send_time(32'd100);
    send_time(32'd132);
  endtask

  task automatic test_random_flights(input int flights, input int words_per_flight);
    logic [31:0] sx, sy, ex, ey;
    int unsigned tot;
    for (int f = 0; f < flights; f++) begin
      // a couple of flights run with both sides never idling
      idle_pct = (f == 3 || f == 4) ? 0 : 22;
      sx = pick_coord();
      sy = pick_coord();
      ex = ($urandom_range(7) == 0) ? sx : pick_coord();
      // bias toward y spans near the free-fall boundary
      ey = ($urandom_range(3) == 0) ? sy - $urandom_range(0, 4000) : pick_coord();
      load_trajectory(sx, sy, pick_coord(), ex, ey, pick_coord(),
                      pick_frames_word(), pick_start_time());
      tot = flight_ms();
      for (int i = 0; i < words_per_flight; i++) send_time(launch_time + pick_dt(tot));
    end
    idle_pct = 22;
  endtask

  // Land the jump either at the end time or from a time before the start,
  // then check that later words produce nothing
  task automatic test_landing();
    logic [31:0] t0;
    int unsigned tot;
    t0 = $urandom_range(1, 1000000);
    load_trajectory(pick_coord(), pick_coord(), pick_coord(),
                    pick_coord(), pick_coord(), pick_coord(),
                    pick_frames_word(), t0);
    tot = flight_ms();
    if ($urandom_range(1)) send_time(t0 - $urandom_range(1, t0));
    else send_time(t0 + tot);
    repeat (4) send_time($urandom);
    wait_idle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_addr  = REG_START_X;
    cfg_wdata = '0;
    idle_pct  = 22;
    failures  = 0;
    org_x = '0; org_y = '0; org_z = '0;
    dst_x = '0; dst_y = '0; dst_z = '0;
    frames      = 16'd1;
    launch_time = '0;
    jump_done   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_axis_extremes();
    test_steep_drop();
    test_fall_boundary();
    test_wrapped_start();
    test_zero_frame_count();
    test_random_flights(10, 70);
    test_landing();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && expected_positions.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
